// ===== hw/rtl/gfp_pkg.sv =====
package gfp_pkg;

    localparam int REASSEMBLY_BYTES_DEF = 256;
    localparam logic [8:0] FRAME_PAYLOAD_BYTES = 9'd256;

    localparam logic [7:0] STX_BYTE      = 8'h02;
    localparam logic [7:0] PAGED_TYPE    = 8'h40;
    localparam logic [8:0] MIN_PAGED_LEN = 9'd3;

    localparam logic [7:0] REC_NAV = 8'd49;
    localparam logic [7:0] REC_RMS = 8'd50;
    localparam logic [7:0] REC_UTC = 8'd16;

    localparam logic [7:0] NAV_MIN_LEN = 8'd104;
    localparam logic [7:0] RMS_MIN_LEN = 8'd44;
    localparam logic [7:0] UTC_MIN_LEN = 8'd8;

    localparam logic [4:0] NAV_FIELDS = 5'd21;
    localparam logic [4:0] RMS_FIELDS = 5'd9;
    localparam logic [4:0] UTC_FIELDS = 5'd1;

    localparam logic [3:0] RMS_START = 4'd8;
    localparam logic [3:0] UTC_START = 4'd6;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    localparam logic ITEM_FIELD = 1'b0;
    localparam logic ITEM_END   = 1'b1;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_NAV  = 2'd1,
        K_RMS  = 2'd2,
        K_UTC  = 2'd3
    } t_rec_kind;

    typedef struct packed {
        logic clr_cnt;
        logic inc_cnt;
        logic ld_type;
        logic ld_len;
        logic pay_byte;
        logic walk_start;
        logic rd_pos;
        logic rd_pos1;
        logic ld_t;
        logic ld_rlen;
        logic rec_start;
        logic skip_rec;
        logic rd_off;
        logic acc;
        logic emit_field;
        logic next_field;
        logic emit_end;
    } t_cmd;

    typedef struct packed {
        logic      is_stx;
        logic      cnt_eq1;
        logic      cnt_eq2;
        logic      cnt_zero;
        logic      pay_done;
        logic      walk_go;
        logic      hdr_fit;
        logic      body_fit;
        logic      rec_none;
        logic      bytes_done;
        logic      fields_done;
        logic      out_free;
    } t_status;

    function automatic logic [3:0] field_bytes(t_rec_kind k, logic [4:0] idx);
        logic [3:0] n;
        n = 4'd4;
        case (k)
            K_NAV: begin
                if (idx == 5'd0) n = 4'd2;
                else if (idx == 5'd2 || idx == 5'd3) n = 4'd1;
                else if (idx inside {[5'd4:5'd6], [5'd11:5'd14]}) n = 4'd8;
                else n = 4'd4;
            end
            K_UTC:   n = 4'd2;
            default: n = 4'd4;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] size_code(logic [3:0] n);
        logic [1:0] c;
        case (n)
            4'd1:    c = WIDTH_8;
            4'd2:    c = WIDTH_16;
            4'd4:    c = WIDTH_32;
            default: c = WIDTH_64;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/gsof_frame_parser.sv =====
// Channel  | Direction | Handshake          | Payload
// rx byte  | in        | i_valid / o_stall  | i_rx_byte
// result   | out       | o_valid / i_stall  | o_item_kind .. o_last
//
// Each valid received byte is taken while frames are being deframed.
// After the trailer of the last page the buffer walk holds o_stall high:
// S_WT..S_WCHK per record header, S_WRD/S_WACC per byte, S_WOUT per field.
// Reset (synchronous, active low) returns to the idle, start-byte hunt.
// A stalled result holds its output register and pauses the walk.
module gsof_frame_parser #(
    parameter int REASSEMBLY_BYTES = gfp_pkg::REASSEMBLY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_item_kind,
    output logic [7:0]  o_record_type,
    output logic [4:0]  o_field_index,
    output logic [1:0]  o_field_width,
    output logic [63:0] o_field_value,
    output logic        o_nav_seen,
    output logic        o_buffer_overflow,
    output logic        o_last
);
    import gfp_pkg::*;

    t_cmd    cmd;
    t_status st;

    // controller: frame phases and walk sequencing
    gfp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_st   (st),
        .o_cmd  (cmd)
    );

    // datapath: header registers, reassembly RAM, field assembly, output reg
    gfp_dp #(.DEPTH(REASSEMBLY_BYTES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_stall          (i_stall),
        .i_cmd            (cmd),
        .o_st             (st),
        .o_valid          (o_valid),
        .o_item_kind      (o_item_kind),
        .o_record_type    (o_record_type),
        .o_field_index    (o_field_index),
        .o_field_width    (o_field_width),
        .o_field_value    (o_field_value),
        .o_nav_seen       (o_nav_seen),
        .o_buffer_overflow(o_buffer_overflow),
        .o_last           (o_last)
    );
endmodule

// ===== hw/rtl/gfp_ram.sv =====
module gfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/gfp_ctrl.sv =====
module gfp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  gfp_pkg::t_status i_st,
    output gfp_pkg::t_cmd    o_cmd
);
    import gfp_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_HDR  = 12'b000000000010,
        S_PAY  = 12'b000000000100,
        S_TRL  = 12'b000000001000,
        S_WT   = 12'b000000010000,
        S_WL   = 12'b000000100000,
        S_WC   = 12'b000001000000,
        S_WCHK = 12'b000010000000,
        S_WRD  = 12'b000100000000,
        S_WACC = 12'b001000000000,
        S_WOUT = 12'b010000000000,
        S_WEND = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   rx_phase;
    logic   take;

    assign rx_phase = (r_state == S_IDLE) || (r_state == S_HDR) ||
                      (r_state == S_PAY) || (r_state == S_TRL);
    assign o_stall  = !rx_phase;
    assign take     = i_valid && rx_phase;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (take && i_st.is_stx) begin
                    o_cmd.clr_cnt = 1'b1;
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                if (take) begin
                    o_cmd.ld_type = i_st.cnt_eq1;
                    if (i_st.cnt_eq2) begin
                        o_cmd.ld_len  = 1'b1;
                        o_cmd.clr_cnt = 1'b1;
                        n_state = S_PAY;
                    end else begin
                        o_cmd.inc_cnt = 1'b1;
                    end
                end
            end
            S_PAY: begin
                if (take) begin
                    o_cmd.pay_byte = 1'b1;
                    if (i_st.pay_done) begin
                        o_cmd.clr_cnt = 1'b1;
                        n_state = S_TRL;
                    end else begin
                        o_cmd.inc_cnt = 1'b1;
                    end
                end
            end
            S_TRL: begin
                if (take) begin
                    if (i_st.cnt_zero) begin
                        o_cmd.inc_cnt = 1'b1;
                    end else begin
                        o_cmd.clr_cnt = 1'b1;
                        if (i_st.walk_go) begin
                            o_cmd.walk_start = 1'b1;
                            n_state = S_WT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_WT: begin
                if (i_st.hdr_fit) begin
                    o_cmd.rd_pos = 1'b1;
                    n_state = S_WL;
                end else begin
                    n_state = S_WEND;
                end
            end
            S_WL: begin
                o_cmd.rd_pos1 = 1'b1;
                o_cmd.ld_t    = 1'b1;
                n_state = S_WC;
            end
            S_WC: begin
                o_cmd.ld_rlen = 1'b1;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (!i_st.body_fit) begin
                    n_state = S_WEND;
                end else if (i_st.rec_none) begin
                    o_cmd.skip_rec = 1'b1;
                    n_state = S_WT;
                end else begin
                    o_cmd.rec_start = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                o_cmd.rd_off = 1'b1;
                n_state = S_WACC;
            end
            S_WACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_st.bytes_done ? S_WOUT : S_WRD;
            end
            S_WOUT: begin
                if (i_st.out_free) begin
                    o_cmd.emit_field = 1'b1;
                    if (i_st.fields_done) begin
                        o_cmd.skip_rec = 1'b1;
                        n_state = S_WT;
                    end else begin
                        o_cmd.next_field = 1'b1;
                        n_state = S_WRD;
                    end
                end
            end
            S_WEND: begin
                if (i_st.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ===== hw/rtl/gfp_dp.sv =====
module gfp_dp #(
    parameter int DEPTH = gfp_pkg::REASSEMBLY_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_stall,
    input  gfp_pkg::t_cmd    i_cmd,
    output gfp_pkg::t_status o_st,
    output logic             o_valid,
    output logic             o_item_kind,
    output logic [7:0]       o_record_type,
    output logic [4:0]       o_field_index,
    output logic [1:0]       o_field_width,
    output logic [63:0]      o_field_value,
    output logic             o_nav_seen,
    output logic             o_buffer_overflow,
    output logic             o_last
);
    import gfp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 2;

    logic [7:0]    r_cnt, r_type, r_len, r_page, r_last_page;
    logic [AW:0]   r_wi;
    logic          r_ovf;
    logic [AW:0]   r_pos, r_off;
    logic [7:0]    r_t, r_rlen;
    t_rec_kind     r_kind;
    logic [4:0]    r_fidx;
    logic [3:0]    r_rem, r_fsize;
    logic [63:0]   r_val;
    logic          r_nav;
    logic          r_ovalid;

    logic [8:0]    paylen;
    logic          paged;
    logic          we;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    t_rec_kind     kind;
    logic [3:0]    start;
    logic [4:0]    kind_fields;
    logic [SW-1:0] body, body_end;
    logic [3:0]    nsize;

    assign paylen = (r_len == 8'd0) ? FRAME_PAYLOAD_BYTES : {1'b0, r_len};
    assign paged  = (r_type == PAGED_TYPE) && (paylen >= MIN_PAGED_LEN);
    assign we     = i_cmd.pay_byte && paged && (r_cnt >= 8'd3) &&
                    (r_wi < (AW+1)'(DEPTH));

    always_comb begin
        if (i_cmd.rd_pos1)     raddr = AW'(r_pos + 1'b1);
        else if (i_cmd.rd_off) raddr = r_off[AW-1:0];
        else                   raddr = r_pos[AW-1:0];
    end

    gfp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_wi[AW-1:0]),
        .i_wdata(i_rx_byte),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        kind = K_NONE; start = 4'd0;
        if (r_t == REC_NAV && r_rlen >= NAV_MIN_LEN) begin
            kind = K_NAV;
        end else if (r_t == REC_RMS && r_rlen >= RMS_MIN_LEN) begin
            kind = K_RMS; start = RMS_START;
        end else if (r_t == REC_UTC && r_rlen >= UTC_MIN_LEN) begin
            kind = K_UTC; start = UTC_START;
        end
    end

    always_comb begin
        case (r_kind)
            K_NAV:   kind_fields = NAV_FIELDS;
            K_RMS:   kind_fields = RMS_FIELDS;
            default: kind_fields = UTC_FIELDS;
        endcase
    end

    assign body     = SW'(r_pos) + SW'(2);
    assign body_end = body + SW'(r_rlen);
    assign nsize    = field_bytes(r_kind, r_fidx + 5'd1);

    assign o_st.is_stx      = (i_rx_byte == STX_BYTE);
    assign o_st.cnt_eq1     = (r_cnt == 8'd1);
    assign o_st.cnt_eq2     = (r_cnt == 8'd2);
    assign o_st.cnt_zero    = (r_cnt == 8'd0);
    assign o_st.pay_done    = ({1'b0, r_cnt} + 9'd1) >= paylen;
    assign o_st.walk_go     = paged && (r_page == r_last_page);
    assign o_st.hdr_fit     = body <= SW'(r_wi);
    assign o_st.body_fit    = body_end <= SW'(r_wi);
    assign o_st.rec_none    = (kind == K_NONE);
    assign o_st.bytes_done  = (r_rem == 4'd0);
    assign o_st.fields_done = (r_fidx == kind_fields - 5'd1);
    assign o_st.out_free    = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_type      <= '0;
            r_len       <= '0;
            r_page      <= '0;
            r_last_page <= '0;
            r_wi        <= '0;
            r_ovf       <= 1'b0;
            r_ovalid    <= 1'b0;
            r_nav       <= 1'b0;
        end else begin
            if (i_cmd.clr_cnt)      r_cnt <= '0;
            else if (i_cmd.inc_cnt) r_cnt <= r_cnt + 8'd1;
            if (i_cmd.ld_type) r_type <= i_rx_byte;
            if (i_cmd.ld_len)  r_len  <= i_rx_byte;
            if (i_cmd.pay_byte && paged) begin
                if (r_cnt == 8'd1) begin
                    r_page <= i_rx_byte;
                    if (i_rx_byte == 8'd0) begin
                        r_wi  <= '0;
                        r_ovf <= 1'b0;
                    end
                end else if (r_cnt == 8'd2) begin
                    r_last_page <= i_rx_byte;
                end else if (r_cnt >= 8'd3) begin
                    if (we) r_wi  <= r_wi + 1'b1;
                    else    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.walk_start) r_nav <= 1'b0;
            else if (i_cmd.rec_start && kind == K_NAV) r_nav <= 1'b1;
            if (i_cmd.emit_field || i_cmd.emit_end) r_ovalid <= 1'b1;
            else if (!i_stall)                      r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) r_pos <= '0;
        else if (i_cmd.skip_rec) r_pos <= (AW+1)'(body_end);
        if (i_cmd.ld_t)    r_t    <= rdata;
        if (i_cmd.ld_rlen) r_rlen <= rdata;
        if (i_cmd.rec_start) begin
            r_kind  <= kind;
            r_off   <= (AW+1)'(body + SW'(start));
            r_fidx  <= '0;
            r_rem   <= field_bytes(kind, 5'd0);
            r_fsize <= field_bytes(kind, 5'd0);
            r_val   <= '0;
        end else if (i_cmd.next_field) begin
            r_fidx  <= r_fidx + 5'd1;
            r_rem   <= nsize;
            r_fsize <= nsize;
            r_val   <= '0;
        end else begin
            if (i_cmd.rd_off) begin
                r_off <= r_off + 1'b1;
                r_rem <= r_rem - 4'd1;
            end
            if (i_cmd.acc) r_val <= {r_val[55:0], rdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_field) begin
            o_item_kind       <= ITEM_FIELD;
            o_record_type     <= r_t;
            o_field_index     <= r_fidx;
            o_field_width     <= size_code(r_fsize);
            o_field_value     <= r_val;
            o_nav_seen        <= 1'b0;
            o_buffer_overflow <= 1'b0;
            o_last            <= 1'b0;
        end else if (i_cmd.emit_end) begin
            o_item_kind       <= ITEM_END;
            o_record_type     <= '0;
            o_field_index     <= '0;
            o_field_width     <= WIDTH_8;
            o_field_value     <= '0;
            o_nav_seen        <= r_nav;
            o_buffer_overflow <= r_ovf;
            o_last            <= 1'b1;
        end
    end

    assign o_valid = r_ovalid;
endmodule
